// ===== rtl/core/xor_key_escape_codec_assert.svh =====
`ifndef XOR_KEY_ESCAPE_CODEC_ASSERT_SVH
`define XOR_KEY_ESCAPE_CODEC_ASSERT_SVH

// same-cycle implication, checked outside reset
`define XKEC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define XKEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/xkec_pkg.sv =====
package xkec_pkg;

    // special characters
    localparam logic [7:0] ESC_CH  = 8'h5C;
    localparam logic [7:0] HEX_CH  = 8'h78;
    localparam logic [7:0] MARK_CH = 8'h01;
    localparam logic [7:0] BAD_CH  = 8'h3F;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_DELIM  = 2'd1;
    localparam logic [1:0] CFG_KEYLEN = 2'd2;

    localparam logic [6:0] KEYLEN_RST = 7'd64;

    // packet queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       mode;
        logic [7:0] delimiter;
        logic [6:0] key_length;
    } cfg_t;

    // up to eight output characters of one string byte, bytes[0] leaves first
    typedef struct packed {
        logic            last;
        logic [3:0]      cnt;
        logic [7:0][7:0] bytes;
    } pkt_t;

    typedef struct packed {
        logic valid;
        pkt_t pkt;
    } q_head_t;

    // lowercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + {4'd0, v};
        end
        return 8'h57 + {4'd0, v};
    endfunction

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            return {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return 5'd0;
    endfunction

endpackage

// ===== rtl/core/xkec_ram.sv =====
module xkec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/xkec_front.sv =====
`include "xor_key_escape_codec_assert.svh"

module xkec_front #(
    parameter int KEY_DEPTH = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic          in_req_type,
    input  logic [5:0]    in_key_slot,
    input  logic [7:0]    in_byte,
    input  logic          in_first,
    input  logic          in_last,
    input  xkec_pkg::cfg_t cfg,
    output logic          stage_busy,
    output logic          push_valid,
    output xkec_pkg::pkt_t push_pkt
);
    import xkec_pkg::*;

    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int LW = $clog2(KEY_DEPTH + 1);
    localparam int PW = LW + 1;
    localparam logic [7:0] PRINT_LO = 8'h21;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    // parse state plus the decoded characters of one byte (at most four)
    typedef struct packed {
        logic            body;
        logic [1:0]      ph;
        logic            pt;
        logic [3:0]      acc;
        logic [7:0]      held2;
        logic [2:0]      n;
        logic [1:0]      nk;
        logic [3:0][7:0] eb;
        logic [3:0]      ek;
        logic [3:0]      eki;
    } dec_state_t;

    function automatic dec_state_t put_raw(input dec_state_t s, input logic [7:0] b);
        dec_state_t r;
        r = s;
        if (r.n < 3'd4) begin
            r.eb[r.n[1:0]] = b;
            r.ek[r.n[1:0]] = 1'b0;
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic dec_state_t put_key(input dec_state_t s, input logic [7:0] b);
        dec_state_t r;
        r = s;
        if (r.n < 3'd4) begin
            r.eb[r.n[1:0]]  = b;
            r.ek[r.n[1:0]]  = 1'b1;
            r.eki[r.n[1:0]] = r.nk[0];
            r.n  = r.n + 3'd1;
            r.nk = r.nk + 2'd1;
        end
        return r;
    endfunction

    // one decoded character complete: keyed output, marker, or start of echo
    function automatic dec_state_t elem_done(input dec_state_t s, input logic [7:0] val,
                                             input logic [1:0] held, input logic echo,
                                             input logic [7:0] cur);
        dec_state_t r;
        r = s;
        if (r.body) begin
            r = put_key(r, val);
        end else if (val == MARK_CH) begin
            r.body = 1'b1;
        end else begin
            r.pt = 1'b1;
            if (held >= 2'd1) r = put_raw(r, ESC_CH);
            if (held >= 2'd2) r = put_raw(r, HEX_CH);
            if (held == 2'd3) r = put_raw(r, r.held2);
            if (echo) r = put_raw(r, cur);
        end
        return r;
    endfunction

    // character outside any escape
    function automatic dec_state_t fresh(input dec_state_t s, input logic [7:0] c);
        dec_state_t r;
        r = s;
        if (c == ESC_CH) begin
            r.ph = 2'd1;
        end else begin
            r = elem_done(r, c, 2'd0, 1'b1, c);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p, input logic [LW-1:0] len);
        logic [PW-1:0] s;
        s = PW'(p) + PW'(1);
        return (s >= PW'(len)) ? '0 : s[AW-1:0];
    endfunction

    logic          body_reg, body_next;
    logic [1:0]    ph_reg, ph_next;
    logic          pt_reg, pt_next;
    logic [3:0]    acc_reg, acc_next;
    logic [7:0]    held2_reg, held2_next;
    logic [AW-1:0] kp_reg, kp_next;

    logic            st_valid_reg;
    logic            st_dec_reg;
    logic            st_first_reg;
    logic            st_last_reg;
    logic [7:0]      st_byte_reg;
    logic [2:0]      st_n_reg;
    logic [3:0][7:0] st_eb_reg;
    logic [3:0]      st_ek_reg;
    logic [3:0]      st_eki_reg;

    dec_state_t    s0, ds;
    logic          again;
    logic [4:0]    hv;
    logic [1:0]    lph;
    logic          str_acc;
    logic [LW-1:0] len_w;
    logic [AW-1:0] kp_eff, p0, p1, p2;
    logic [1:0]    nk_used;
    logic          key_we;
    logic [7:0]    k0, k1;

    assign str_acc = in_accept & in_req_type;

    // effective key length
    always_comb begin
        if (cfg.key_length == 7'd0) begin
            len_w = LW'(1);
        end else if (int'(cfg.key_length) > KEY_DEPTH) begin
            len_w = LW'(KEY_DEPTH);
        end else begin
            len_w = LW'(cfg.key_length);
        end
    end

    // key positions for up to two keyed characters
    assign kp_eff = in_first ? '0 : kp_reg;
    assign p0     = (LW'(kp_eff) >= len_w) ? '0 : kp_eff;
    assign p1     = nxt(p0, len_w);
    assign p2     = nxt(p1, len_w);

    // escape parser over one raw byte
    always_comb begin
        s0       = '0;
        s0.body  = body_reg & ~in_first;
        s0.ph    = in_first ? 2'd0 : ph_reg;
        s0.acc   = in_first ? 4'd0 : acc_reg;
        s0.pt    = pt_reg & ~in_first;
        s0.held2 = held2_reg;
        ds       = s0;
        again    = 1'b0;
        lph      = 2'd0;
        hv       = hex_val(in_byte);
        if (ds.pt) begin
            ds = put_raw(ds, in_byte);
        end else begin
            case (ds.ph)
                2'd0: ds = fresh(ds, in_byte);
                2'd1: begin
                    if (in_byte == HEX_CH) begin
                        ds.ph = 2'd2;
                    end else begin
                        ds.ph = 2'd0;
                        ds = elem_done(ds, in_byte, 2'd1, 1'b1, in_byte);
                    end
                end
                2'd2: begin
                    if (hv[4]) begin
                        ds.held2 = in_byte;
                        ds.acc   = hv[3:0];
                        ds.ph    = 2'd3;
                    end else begin
                        // bad digit gives '?', the byte is then read afresh
                        ds.ph = 2'd0;
                        ds = elem_done(ds, BAD_CH, 2'd2, 1'b0, in_byte);
                        again = 1'b1;
                    end
                end
                default: begin
                    ds.ph = 2'd0;
                    ds = elem_done(ds, hv[4] ? {ds.acc, hv[3:0]} : {4'd0, ds.acc},
                                   2'd3, 1'b1, in_byte);
                end
            endcase
            if (again) begin
                if (ds.pt) begin
                    ds = put_raw(ds, in_byte);
                end else begin
                    ds = fresh(ds, in_byte);
                end
            end
        end
        // escape cut by end of string
        if (in_last && !ds.pt && ds.ph != 2'd0) begin
            lph   = ds.ph;
            ds.ph = 2'd0;
            ds = elem_done(ds, (lph == 2'd3) ? {4'd0, ds.acc} : BAD_CH, lph, 1'b0, 8'd0);
        end
    end

    // next parse state and key position
    always_comb begin
        nk_used    = cfg.mode ? ds.nk : 2'd1;
        body_next  = body_reg;
        ph_next    = ph_reg;
        pt_next    = pt_reg;
        acc_next   = acc_reg;
        held2_next = held2_reg;
        kp_next    = kp_reg;
        if (str_acc) begin
            if (cfg.mode) begin
                body_next  = ds.body;
                ph_next    = ds.ph;
                pt_next    = ds.pt;
                acc_next   = ds.acc;
                held2_next = ds.held2;
            end else begin
                body_next  = s0.body;
                ph_next    = s0.ph;
                pt_next    = s0.pt;
                acc_next   = s0.acc;
            end
            case (nk_used)
                2'd0:    kp_next = kp_eff;
                2'd1:    kp_next = p1;
                default: kp_next = p2;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_reg     <= 1'b0;
            ph_reg       <= 2'd0;
            pt_reg       <= 1'b0;
            acc_reg      <= 4'd0;
            kp_reg       <= '0;
            st_valid_reg <= 1'b0;
        end else begin
            body_reg     <= body_next;
            ph_reg       <= ph_next;
            pt_reg       <= pt_next;
            acc_reg      <= acc_next;
            kp_reg       <= kp_next;
            st_valid_reg <= str_acc;
        end
    end

    // payload of the stage register
    always_ff @(posedge aclk) begin
        held2_reg <= held2_next;
        if (str_acc) begin
            st_dec_reg   <= cfg.mode;
            st_first_reg <= in_first;
            st_last_reg  <= in_last;
            st_byte_reg  <= in_byte;
            st_n_reg     <= ds.n;
            st_eb_reg    <= ds.eb;
            st_ek_reg    <= ds.ek;
            st_eki_reg   <= ds.eki;
        end
    end

    // key table, duplicated for two reads per byte
    assign key_we = in_accept & ~in_req_type & (int'(in_key_slot) < KEY_DEPTH);

    xkec_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_a (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (AW'(in_key_slot)),
        .wdata (in_byte),
        .raddr (p0),
        .rdata (k0)
    );

    xkec_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_b (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (AW'(in_key_slot)),
        .wdata (in_byte),
        .raddr (p1),
        .rdata (k1)
    );

    // second stage: apply keys and escape, build the packet
    logic [7:0]      c;
    logic [3:0][7:0] tail;
    logic [2:0]      tn;

    always_comb begin
        c    = st_byte_reg ^ k0;
        tail = '0;
        tn   = 3'd4;
        if ((cfg.delimiter != 8'd0 && c == cfg.delimiter) ||
            !(c == ESC_CH || (c >= PRINT_LO && c <= PRINT_HI))) begin
            tail = {hex_char(c[3:0]), hex_char(c[7:4]), HEX_CH, ESC_CH};
        end else if (c == ESC_CH) begin
            tail = {16'd0, ESC_CH, ESC_CH};
            tn   = 3'd2;
        end else begin
            tail = {24'd0, c};
            tn   = 3'd1;
        end

        push_pkt      = '0;
        push_pkt.last = st_last_reg;
        if (st_dec_reg) begin
            for (int i = 0; i < 4; i++) begin
                push_pkt.bytes[i] = st_eb_reg[i] ^
                    (st_ek_reg[i] ? (st_eki_reg[i] ? k1 : k0) : 8'd0);
            end
            push_pkt.cnt = {1'b0, st_n_reg};
        end else if (st_first_reg) begin
            push_pkt.bytes = {tail, hex_char(4'd1), hex_char(4'd0), HEX_CH, ESC_CH};
            push_pkt.cnt   = 4'd4 + {1'b0, tn};
        end else begin
            push_pkt.bytes = {32'd0, tail};
            push_pkt.cnt   = {1'b0, tn};
        end
    end

    assign push_valid = st_valid_reg & (push_pkt.cnt != 4'd0);
    assign stage_busy = st_valid_reg;

    `XKEC_ASSERT_NEXT(a_key_pos_wrap, aclk, aresetn, str_acc && !cfg.mode,
                      LW'(kp_reg) < len_w, "key position beyond key length")

endmodule

// ===== rtl/core/xkec_queue.sv =====
`include "xor_key_escape_codec_assert.svh"

module xkec_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    input  xkec_pkg::pkt_t         push_pkt,
    input  logic                   pop,
    output xkec_pkg::q_head_t      head,
    output logic [xkec_pkg::QCW-1:0] count
);
    import xkec_pkg::*;

    pkt_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        end
        if (push_valid && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (!push_valid && pop) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.pkt   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    `XKEC_ASSERT_NOW(a_no_overflow, aclk, aresetn, push_valid && !pop,
                     count_reg < QCW'(QDEPTH), "packet queue overflow")
    `XKEC_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop,
                     count_reg != '0, "packet queue underflow")

endmodule

// ===== rtl/core/xkec_back.sv =====
`include "xor_key_escape_codec_assert.svh"

module xkec_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  xkec_pkg::q_head_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import xkec_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       mv_reg, mv_next;
    logic [7:0] md_reg, md_next;
    logic       ml_reg, ml_next;
    logic       load;
    logic       at_end;

    // one character per ready cycle to output register
    always_comb begin
        load     = head.valid & (~mv_reg | m_tready);
        at_end   = ({1'b0, idx_reg} == head.pkt.cnt - 4'd1);
        idx_next = idx_reg;
        mv_next  = mv_reg & ~m_tready;
        md_next  = md_reg;
        ml_next  = ml_reg;
        pop      = 1'b0;
        if (load) begin
            mv_next = 1'b1;
            md_next = head.pkt.bytes[idx_reg];
            ml_next = head.pkt.last & at_end;
            if (at_end) begin
                pop      = 1'b1;
                idx_next = 3'd0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 3'd0;
            mv_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
        ml_reg <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    `XKEC_ASSERT_NOW(a_idx_in_packet, aclk, aresetn, head.valid,
                     {1'b0, idx_reg} < head.pkt.cnt, "character index past packet end")

endmodule

// ===== rtl/core/xor_key_escape_codec.sv =====
// channel   dir  tdata (low bit up)                  tuser (low bit up)   tlast
// s_*       in   key_slot[5:0], in_byte[13:6], 0 pad  req_type, first      last
// m_*       out  out_byte[7:0]                        -                    out_last
// cfg_*     in   write port: cfg_wr_en, cfg_index, cfg_wdata (no read-back)
//
// an input transaction is taken every cycle while the packet queue has room;
// string bytes pass the stage register and the packet queue into the output register
// characters leave one per cycle while m_tready holds, so a string byte costs zero
// to eight output characters (four for a hex escape, five to eight for a first byte
// in encrypt mode); the result port is the limit: sustained rate is set by output
// characters; aresetn is synchronous, active low; the key table is not cleared
// s_tready drops only in reset or when queue plus stage hold four packets

module xor_key_escape_codec #(
    parameter int KEY_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // key_slot, in_byte
    input  logic [1:0]  s_tuser,   // req_type, first
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import xkec_pkg::*;

    logic       mode_reg, mode_next;
    logic [7:0] delim_reg, delim_next;
    logic [6:0] klen_reg, klen_next;
    cfg_t       cfg;

    logic           in_accept;
    logic           stage_busy;
    logic           push_valid;
    pkt_t           push_pkt;
    logic           pop;
    q_head_t        head;
    logic [QCW-1:0] q_count;
    logic [QCW:0]   inflight;

    // configuration registers
    always_comb begin
        mode_next  = mode_reg;
        delim_next = delim_reg;
        klen_next  = klen_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:   mode_next  = cfg_wdata[0];
                CFG_DELIM:  delim_next = cfg_wdata;
                CFG_KEYLEN: klen_next  = cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            delim_reg <= 8'd0;
            klen_reg  <= KEYLEN_RST;
        end else begin
            mode_reg  <= mode_next;
            delim_reg <= delim_next;
            klen_reg  <= klen_next;
        end
    end

    assign cfg.mode       = mode_reg;
    assign cfg.delimiter  = delim_reg;
    assign cfg.key_length = klen_reg;

    // credit: queued packets plus the one in the front stage
    assign inflight  = (QCW + 1)'(q_count) + (QCW + 1)'(stage_busy);
    assign s_tready  = aresetn & (inflight < (QCW + 1)'(QDEPTH));
    assign in_accept = s_tvalid & s_tready;

    xkec_front #(.KEY_DEPTH(KEY_DEPTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_req_type (s_tuser[0]),
        .in_key_slot (s_tdata[5:0]),
        .in_byte     (s_tdata[13:6]),
        .in_first    (s_tuser[1]),
        .in_last     (s_tlast),
        .cfg         (cfg),
        .stage_busy  (stage_busy),
        .push_valid  (push_valid),
        .push_pkt    (push_pkt)
    );

    xkec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_pkt   (push_pkt),
        .pop        (pop),
        .head       (head),
        .count      (q_count)
    );

    xkec_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xkec_pkg::*;

    localparam int KEY_SLOTS     = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;

    // request kinds and modes
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_CHAR = 1'b1;
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef enum logic [1:0] {STIM_ITEM, STIM_CFG, STIM_SYNC} stim_kind_t;

    typedef struct {
        stim_kind_t  kind;
        logic        req;
        logic [5:0]  slot;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [1:0]  cfg_idx;
        logic [7:0]  cfg_val;
        int          send_pct;
        int          recv_pct;
    } stim_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_char_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // key_slot, in_byte, zero pad
    logic [1:0]  s_tuser   = '0;   // req_type, first
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // out_byte
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    xor_key_escape_codec #(
        .KEY_DEPTH(KEY_SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // codec shadow state
    logic [7:0] key_mem [KEY_SLOTS];
    logic [5:0] key_pos   = '0;
    logic [2:0] parse_st  = '0;
    logic [7:0] hex_acc   = '0;
    logic [7:0] held_mem [4];
    logic       pass_thru = 1'b0;
    logic       cfg_mode  = MODE_ENC;
    logic [7:0] cfg_delim = '0;
    logic [6:0] cfg_klen  = KEYLEN_RST;

    out_char_t  predicted_chars[$];
    int         step_chars;

    // stimulus side
    stim_t      stim_queue[$];
    stim_t      cur_item;
    stim_t      cur_op;
    logic [7:0] gen_key [KEY_SLOTS];
    logic [7:0] text_buf[$];
    int         gen_send_pct;
    int         gen_recv_pct;
    int         recv_idle_pct = 0;
    int         settle_cnt    = 0;
    int         stall_cycles  = 0;
    int         err_count     = 0;
    int         items_taken   = 0;
    int         chars_checked = 0;
    int         cfg_writes    = 0;
    logic       cfg_go;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
    endfunction

    // value of a hex digit character, -1 if not a digit
    function automatic int digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    // next key byte, position wraps at the clamped key length
    function automatic logic [7:0] key_advance();
        int len;
        int pos;
        len = int'(cfg_klen);
        if (len == 0) len = 1;
        if (len > KEY_SLOTS) len = KEY_SLOTS;
        pos = int'(key_pos);
        if (pos >= len) pos = 0;
        key_advance = key_mem[pos];
        pos++;
        key_pos = (pos >= len) ? 6'd0 : 6'(pos);
    endfunction

    task automatic emit(input logic [7:0] b);
        if (step_chars < 8) begin
            predicted_chars.push_back('{data: b, last: 1'b0});
            step_chars++;
        end
    endtask

    task automatic emit_hex(input logic [7:0] b);
        emit(ESC_CH);
        emit(HEX_CH);
        emit(nibble_char(b[7:4]));
        emit(nibble_char(b[3:0]));
    endtask

    // one decoded character complete; held raw bytes are echoed when unmarked
    task automatic char_done(input logic [7:0] val, input int held, input logic echo_cur,
                             input logic [7:0] cur);
        if (parse_st[2]) begin
            emit(val ^ key_advance());
        end else if (val == MARK_CH) begin
            parse_st = 3'b100;
        end else begin
            pass_thru = 1'b1;
            for (int i = 0; i < held && i < 4; i++) emit(held_mem[i]);
            if (echo_cur) emit(cur);
        end
    endtask

    task automatic unescape_byte(input logic [7:0] c, input logic lst);
        bit         again;
        int         d;
        logic [2:0] body;
        logic [1:0] ph;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            if (pass_thru) begin
                emit(c);
                break;
            end
            body = parse_st & 3'b100;
            d = digit_value(c);
            case (parse_st[1:0])
                2'd0: begin
                    if (c == ESC_CH) begin
                        held_mem[0] = c;
                        parse_st = body | 3'd1;
                    end else begin
                        char_done(c, 0, 1'b1, c);
                    end
                end
                2'd1: begin
                    if (c == HEX_CH) begin
                        held_mem[1] = c;
                        parse_st = body | 3'd2;
                    end else begin
                        parse_st = body;
                        char_done(c, 1, 1'b1, c);
                    end
                end
                2'd2: begin
                    if (d >= 0) begin
                        held_mem[2] = c;
                        hex_acc = 8'(d);
                        parse_st = body | 3'd3;
                    end else begin
                        // bad digit gives '?' and the byte is read again
                        parse_st = body;
                        char_done(BAD_CH, 2, 1'b0, c);
                        again = 1'b1;
                    end
                end
                default: begin
                    parse_st = body;
                    char_done((d >= 0) ? {hex_acc[3:0], 4'(d)} : hex_acc, 3, 1'b1, c);
                end
            endcase
        end
        // escape cut by the end of the string
        if (lst && !pass_thru && parse_st[1:0] != 2'd0) begin
            ph = parse_st[1:0];
            parse_st = parse_st & 3'b100;
            char_done((ph == 2'd3) ? hex_acc : BAD_CH, int'(ph), 1'b0, 8'h00);
        end
    endtask

    task automatic escape_byte(input logic [7:0] din, input logic fst);
        logic [7:0] c;
        if (fst) emit_hex(MARK_CH);
        c = din ^ key_advance();
        if (cfg_delim != 8'h00 && c == cfg_delim) begin
            emit_hex(c);
        end else if (c == ESC_CH) begin
            emit(ESC_CH);
            emit(ESC_CH);
        end else if (c >= 8'h21 && c <= 8'h7E) begin
            emit(c);
        end else begin
            emit_hex(c);
        end
    endtask

    task automatic codec_predict(input stim_t it);
        out_char_t tail;
        step_chars = 0;
        if (it.req == REQ_KEY) begin
            key_mem[it.slot] = it.data;
        end else begin
            if (it.first) begin
                key_pos   = '0;
                parse_st  = '0;
                hex_acc   = '0;
                pass_thru = 1'b0;
            end
            if (cfg_mode == MODE_DEC) unescape_byte(it.data, it.last);
            else escape_byte(it.data, it.first);
            if (it.last && step_chars > 0) begin
                tail = predicted_chars.pop_back();
                tail.last = 1'b1;
                predicted_chars.push_back(tail);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at %0t ns: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // stimulus queue helpers
    task automatic push_entry(input stim_kind_t k, input logic r, input logic [5:0] s,
                              input logic [7:0] d, input logic f, input logic l,
                              input logic [1:0] ci, input logic [7:0] cv);
        stim_queue.push_back('{kind: k, req: r, slot: s, data: d, first: f, last: l,
                               cfg_idx: ci, cfg_val: cv,
                               send_pct: gen_send_pct, recv_pct: gen_recv_pct});
    endtask

    task automatic push_key(input logic [5:0] s, input logic [7:0] v);
        gen_key[s] = v;
        push_entry(STIM_ITEM, REQ_KEY, s, v, 1'($urandom), 1'($urandom), '0, '0);
    endtask

    task automatic push_cfg(input logic [1:0] idx, input logic [7:0] v);
        push_entry(STIM_CFG, REQ_KEY, '0, '0, 1'b0, 1'b0, idx, v);
    endtask

    task automatic push_sync();
        push_entry(STIM_SYNC, REQ_KEY, '0, '0, 1'b0, 1'b0, '0, '0);
    endtask

    // send the text buffer as one string, optionally without the first flag
    task automatic push_text(input bit open);
        for (int i = 0; i < text_buf.size(); i++) begin
            push_entry(STIM_ITEM, REQ_CHAR, 6'($urandom), text_buf[i], open && i == 0,
                       i == text_buf.size() - 1, '0, '0);
        end
        text_buf.delete();
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == ESC_CH);
        return c;
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] c;
        do c = 8'($urandom); while (digit_value(c) >= 0);
        return c;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
    endfunction

    // escaped text for decrypt: mostly marked, well-formed, some broken escapes
    task automatic gen_cipher_text();
        int v;
        int ntok;
        int kind;
        v = $urandom_range(0, 99);
        if (v < 75) begin
            text_buf.push_back(ESC_CH);
            text_buf.push_back(HEX_CH);
            text_buf.push_back(8'h30);
            text_buf.push_back(8'h31);
        end else if (v < 85) begin
            text_buf.push_back(MARK_CH);
        end
        ntok = $urandom_range(0, 5);
        repeat (ntok) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                text_buf.push_back(rand_plain());
            end else if (kind < 60) begin
                text_buf.push_back(ESC_CH);
                text_buf.push_back(HEX_CH);
                text_buf.push_back(rand_hex_char());
                text_buf.push_back(rand_hex_char());
            end else if (kind < 70) begin
                text_buf.push_back(ESC_CH);
                text_buf.push_back(ESC_CH);
            end else if (kind < 78) begin
                text_buf.push_back(ESC_CH);
                text_buf.push_back(HEX_CH);
                text_buf.push_back(rand_nonhex());
            end else if (kind < 86) begin
                text_buf.push_back(ESC_CH);
                text_buf.push_back(HEX_CH);
                text_buf.push_back(rand_hex_char());
                text_buf.push_back(rand_nonhex());
            end else if (kind < 93) begin
                text_buf.push_back(ESC_CH);
                text_buf.push_back(rand_plain());
            end else begin
                text_buf.push_back(8'($urandom));
            end
        end
        // escape left open at the end of the string
        v = $urandom_range(0, 99);
        if (v < 18) text_buf.push_back(ESC_CH);
        if (v >= 6 && v < 18) text_buf.push_back(HEX_CH);
        if (v >= 12 && v < 18) text_buf.push_back(rand_hex_char());
        if (text_buf.size() == 0) text_buf.push_back(rand_plain());
    endtask

    // plain text for encrypt; with a one-byte key, aim at delimiter and backslash
    task automatic gen_plain_text(input bit aim, input logic [7:0] delim);
        int len;
        int v;
        len = $urandom_range(1, 6);
        repeat (len) begin
            v = $urandom_range(0, 99);
            if (aim && v < 20 && delim != 8'h00) text_buf.push_back(delim ^ gen_key[0]);
            else if (aim && v < 35) text_buf.push_back(ESC_CH ^ gen_key[0]);
            else text_buf.push_back(8'($urandom));
        end
    endtask

    task automatic run_segment(input logic mode_v, input logic [7:0] delim_v,
                               input logic [6:0] klen_v, input int target);
        int n;
        n = 0;
        push_cfg(CFG_MODE, {7'd0, mode_v});
        push_cfg(CFG_DELIM, delim_v);
        push_cfg(CFG_KEYLEN, {1'b0, klen_v});
        while (n < target) begin
            if ($urandom_range(0, 99) < 10) begin
                push_key(6'($urandom), 8'($urandom));
                n++;
            end
            if ($urandom_range(0, 99) < 4) push_sync();
            if (mode_v == MODE_DEC) gen_cipher_text();
            else gen_plain_text(klen_v == 7'd1, delim_v);
            n += text_buf.size();
            push_text($urandom_range(0, 99) >= 15);
        end
    endtask

    // driver: presents queued transactions, writes registers only when idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
            settle_cnt = 0;
        end else begin
            cfg_go = 1'b0;
            if (s_tvalid && s_tready) begin
                codec_predict(cur_item);
                items_taken++;
            end
            if (!s_tvalid && predicted_chars.size() == 0) settle_cnt++;
            else settle_cnt = 0;

            if (!(s_tvalid && !s_tready)) begin
                if (stim_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (stim_queue[0].kind == STIM_ITEM) begin
                    if ($urandom_range(0, 99) < stim_queue[0].send_pct) begin
                        s_tvalid <= 1'b0;
                    end else begin
                        cur_item = stim_queue.pop_front();
                        s_tvalid      <= 1'b1;
                        s_tdata       <= {2'b00, cur_item.data, cur_item.slot};
                        s_tuser       <= {cur_item.first, cur_item.req};
                        s_tlast       <= cur_item.last;
                        recv_idle_pct <= cur_item.recv_pct;
                    end
                end else begin
                    // register write or drain pause: wait for the block to go quiet
                    s_tvalid <= 1'b0;
                    if (settle_cnt >= SETTLE_CYCLES) begin
                        cur_op = stim_queue.pop_front();
                        settle_cnt = 0;
                        if (cur_op.kind == STIM_CFG) begin
                            cfg_go = 1'b1;
                            cfg_index <= cur_op.cfg_idx;
                            cfg_wdata <= cur_op.cfg_val;
                            cfg_writes++;
                            case (cur_op.cfg_idx)
                                CFG_MODE:   cfg_mode  = cur_op.cfg_val[0];
                                CFG_DELIM:  cfg_delim = cur_op.cfg_val;
                                CFG_KEYLEN: cfg_klen  = cur_op.cfg_val[6:0];
                                default: ;
                            endcase
                        end
                    end
                end
            end
            cfg_wr_en <= cfg_go;
        end
    end

    // monitor: checks each output transaction against the oldest prediction
    always @(posedge aclk) begin
        out_char_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                chars_checked++;
                if (predicted_chars.size() == 0) begin
                    report_mismatch("unexpected character", int'(m_tdata), 0);
                end else begin
                    want = predicted_chars.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch("out_byte", int'(m_tdata), int'(want.data));
                    if (m_tlast !== want.last)
                        report_mismatch("out_last", int'(m_tlast), int'(want.last));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: cycles with no transaction and no register write
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        // phase one idling: sender 36, receiver 48
        gen_send_pct = 36;
        gen_recv_pct = 48;

        // load every key slot so no unwritten entry is ever read
        for (int i = 0; i < KEY_SLOTS; i++) push_key(6'(i), 8'($urandom));

        // directed: one zero key byte, so encrypt sees the raw input
        push_cfg(CFG_KEYLEN, 8'd1);
        push_cfg(CFG_DELIM, 8'h00);
        push_cfg(CFG_MODE, {7'd0, MODE_ENC});
        push_key(6'd0, 8'h00);
        push_key(6'd63, 8'hFF);
        text_buf = '{8'h00, 8'h20, 8'h21, 8'h7E, 8'h7F, 8'h80, 8'hFF, ESC_CH};
        push_text(1'b1);
        // delimiter of backslash wins over doubling
        push_cfg(CFG_DELIM, ESC_CH);
        text_buf = '{ESC_CH};
        push_text(1'b1);
        // decrypt: marker, doubled backslash, mixed-case hex, bad digit, cut digit
        push_cfg(CFG_DELIM, 8'h00);
        push_cfg(CFG_MODE, {7'd0, MODE_DEC});
        text_buf = '{ESC_CH, HEX_CH, 8'h30, 8'h31, ESC_CH, ESC_CH, ESC_CH, HEX_CH,
                     8'h46, 8'h66, ESC_CH, HEX_CH, 8'h7A, ESC_CH, HEX_CH, 8'h37};
        push_text(1'b1);
        push_sync();

        // random part
        run_segment(MODE_ENC, 8'($urandom_range(1, 255)), 7'd64, 10);
        run_segment(MODE_DEC, 8'h00, 7'd64, 10);
        gen_send_pct = 48;
        gen_recv_pct = 36;
        run_segment(MODE_ENC, 8'($urandom_range(1, 255)), 7'd1, 10);
        run_segment(MODE_DEC, 8'($urandom), 7'($urandom_range(2, 63)), 10);
        gen_send_pct = 0;
        gen_recv_pct = 0;
        run_segment(MODE_ENC, 8'hFF, 7'($urandom_range(1, 64)), 10);
        run_segment(MODE_DEC, 8'h00, 7'd1, 10);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(stim_queue.size() == 0 && !s_tvalid && predicted_chars.size() == 0)
               && stall_cycles < STALL_LIMIT)
            @(posedge aclk);

        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
        end else begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            $display("covered %0d input and %0d output transactions, %0d register writes",
                     items_taken, chars_checked, cfg_writes);
            $display("both modes, key lengths 1 to 64, delimiter off, on and 0xff");
            if (err_count == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end
        $finish;
    end

endmodule
